@@ design/spisram_pkg.sv @@
// ----------------------------------------------------------------------------
// spisram_pkg
// shared opcodes, mode codes and inter-module control structs for the
// spi serial sram slave
// ----------------------------------------------------------------------------
package spisram_pkg;

  // command opcodes
  localparam logic [7:0] OP_READ  = 8'h03;
  localparam logic [7:0] OP_WRITE = 8'h02;
  localparam logic [7:0] OP_RDSR  = 8'h05;
  localparam logic [7:0] OP_WRSR  = 8'h01;

  // status register mode field
  localparam logic [1:0] MODE_BYTE = 2'b00;
  localparam logic [1:0] MODE_SEQ  = 2'b01;
  localparam logic [1:0] MODE_PAGE = 2'b10;

  // value of the kind field for a chip deselect
  localparam logic KIND_DESELECT = 1'b1;

  // memory port strobes from the command sequencer
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_req_t;

  // per-word result info handed to the output pipe
  typedef struct packed {
    logic       use_ram;
    logic [7:0] data;
  } out_info_t;

endpackage

@@ design/spi_sram_slave_with_modes_top.sv @@
// ----------------------------------------------------------------------------
// spi_sram_slave_with_modes_top
// spi serial sram slave at byte-slot level, with byte, page and sequential
// modes selected by the status register
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake              payload
//  -------   ---   --------------------   ----------------------------------
//  in        in    in_valid / in_ready    kind (1 = deselect), mosi_byte[7:0]
//  out       out   out_valid / out_ready  miso_byte[7:0]
//
//  one word accepted per cycle sustained while the output is not stalled;
//  each word gives one result word, which passes the ram read register, then the output register
//  reset clears the sequencer, the status register and the result pipe; the
//  byte array is not cleared and reads of unwritten bytes are undefined
//  a stalled output lets one more word in (read stage), then in_ready drops
//  MEM_BYTES and PAGE_BYTES are powers of two
//
module spi_sram_slave_with_modes_top #(
  parameter int MEM_BYTES  = 32768,
  parameter int PAGE_BYTES = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       kind,
  input  logic [7:0] mosi_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] miso_byte
);

  localparam int AW = $clog2(MEM_BYTES);
  localparam int PW = $clog2(PAGE_BYTES);

  logic                   accept;
  spisram_pkg::mem_req_t  req;
  logic [AW-1:0]          mem_addr;
  logic [7:0]             rdata;
  spisram_pkg::out_info_t info;

  assign accept = in_valid && in_ready;

  // command sequencer: decides this word's ram access and result source
  spisram_ctrl #(
    .AW (AW),
    .PW (PW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .kind      (kind),
    .mosi_byte (mosi_byte),
    .req       (req),
    .mem_addr  (mem_addr),
    .info      (info)
  );

  // byte array; a write and a following read of the same byte are in
  // separate cycles, so the read always sees the new value
  spisram_mem #(
    .DEPTH (MEM_BYTES),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .req   (req),
    .addr  (mem_addr),
    .wdata (mosi_byte),
    .rdata (rdata)
  );

  // result pipe: picks ram data or sequencer byte, buffers against stalls
  spisram_out u_out (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .info      (info),
    .rdata     (rdata),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .miso_byte (miso_byte)
  );

endmodule

@@ design/spisram_mem.sv @@
// ----------------------------------------------------------------------------
// spisram_mem
// single-port byte array, one access per cycle, registered read data
// ----------------------------------------------------------------------------
module spisram_mem #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15
) (
  input  logic                  clk,
  input  spisram_pkg::mem_req_t req,
  input  logic [AW-1:0]         addr,
  input  logic [7:0]            wdata,
  output logic [7:0]            rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[addr] <= wdata;
    end
    if (req.rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ design/spisram_ctrl.sv @@
// ----------------------------------------------------------------------------
// spisram_ctrl
// command sequencer: opcode decode, address assembly, mode-dependent address
// advance and status register
// ----------------------------------------------------------------------------
module spisram_ctrl #(
  parameter int AW = 15,
  parameter int PW = 5
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic                   kind,
  input  logic [7:0]             mosi_byte,
  output spisram_pkg::mem_req_t  req,
  output logic [AW-1:0]          mem_addr,
  output spisram_pkg::out_info_t info
);

  localparam int W = (AW > 16) ? AW : 16;

  typedef enum logic [2:0] {
    PH_OPCODE,
    PH_ADDR_HI,
    PH_ADDR_LO,
    PH_DATA,
    PH_STATUS_W,
    PH_STATUS_R,
    PH_IGNORE
  } phase_t;

  phase_t        phase;
  logic          is_read;
  logic [1:0]    mode_bits;
  logic          hold_en;
  logic [AW-1:0] addr;
  logic          byte_done;

  logic [W-1:0]  hi_full;
  logic [W-1:0]  lo_full;
  logic [AW-1:0] seq_next;
  logic [AW-1:0] page_next;
  logic          auto_inc;
  logic          data_slot;

  assign hi_full  = W'({mosi_byte, 8'h00});
  assign lo_full  = (W'(addr) & W'(16'hFF00)) | W'(mosi_byte);
  assign seq_next = addr + AW'(1);

  // page wrap keeps the page base; a page wider than the array wraps as sequential
  generate
    if (PW >= AW) begin : g_page_wide
      assign page_next = seq_next;
    end else begin : g_page_wrap
      assign page_next = {addr[AW-1:PW], addr[PW-1:0] + PW'(1)};
    end
  endgenerate

  assign auto_inc  = (mode_bits == spisram_pkg::MODE_PAGE) ||
                     (mode_bits == spisram_pkg::MODE_SEQ);
  assign data_slot = accept && (kind != spisram_pkg::KIND_DESELECT) &&
                     (phase == PH_DATA) && !byte_done;

  always_comb begin
    req.rd_en    = data_slot && is_read;
    req.wr_en    = data_slot && !is_read;
    mem_addr     = addr;
    info.use_ram = req.rd_en;
    info.data    = 8'h00;
    if ((kind != spisram_pkg::KIND_DESELECT) && (phase == PH_STATUS_R)) begin
      info.data = {mode_bits, 5'b00000, hold_en};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_OPCODE;
      is_read   <= 1'b0;
      mode_bits <= spisram_pkg::MODE_BYTE;
      hold_en   <= 1'b0;
      addr      <= '0;
      byte_done <= 1'b0;
    end else if (accept) begin
      if (kind == spisram_pkg::KIND_DESELECT) begin
        phase     <= PH_OPCODE;
        byte_done <= 1'b0;
      end else begin
        unique case (phase)
          PH_OPCODE: begin
            is_read   <= (mosi_byte == spisram_pkg::OP_READ);
            byte_done <= 1'b0;
            unique case (mosi_byte) inside
              spisram_pkg::OP_READ, spisram_pkg::OP_WRITE: phase <= PH_ADDR_HI;
              spisram_pkg::OP_RDSR:                        phase <= PH_STATUS_R;
              spisram_pkg::OP_WRSR:                        phase <= PH_STATUS_W;
              default:                                     phase <= PH_IGNORE;
            endcase
          end
          PH_ADDR_HI: begin
            addr  <= hi_full[AW-1:0];
            phase <= PH_ADDR_LO;
          end
          PH_ADDR_LO: begin
            addr  <= lo_full[AW-1:0];
            phase <= PH_DATA;
          end
          PH_DATA: begin
            if (!byte_done) begin
              if (mode_bits == spisram_pkg::MODE_SEQ) begin
                addr <= seq_next;
              end else if (auto_inc) begin
                addr <= page_next;
              end else begin
                byte_done <= 1'b1;
              end
            end
          end
          PH_STATUS_W: begin
            mode_bits <= mosi_byte[7:6];
            hold_en   <= mosi_byte[0];
            phase     <= PH_IGNORE;
          end
          PH_STATUS_R: begin
            phase <= PH_IGNORE;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

@@ design/spisram_out.sv @@
// ----------------------------------------------------------------------------
// spisram_out
// two-deep result pipe: ram read stage then output register
// ----------------------------------------------------------------------------
module spisram_out (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  spisram_pkg::out_info_t info,
  input  logic [7:0]             rdata,
  input  logic                   out_ready,
  output logic                   in_ready,
  output logic                   out_valid,
  output logic [7:0]             miso_byte
);

  logic       p_valid;
  logic       p_use_ram;
  logic [7:0] p_data;
  logic       p_adv;

  // ram read data holds while the read stage waits, as no new word enters
  assign p_adv    = p_valid && (!out_valid || out_ready);
  assign in_ready = !p_valid || p_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        p_valid <= 1'b1;
      end else if (p_adv) begin
        p_valid <= 1'b0;
      end
      if (p_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_use_ram <= info.use_ram;
      p_data    <= info.data;
    end
    if (p_adv) begin
      miso_byte <= p_use_ram ? rdata : p_data;
    end
  end

endmodule

@@ design/spisram_checker.sv @@
// ----------------------------------------------------------------------------
// spisram_checker
// port-level checks on the result pipe timing of the sram slave
// ----------------------------------------------------------------------------
module spisram_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] miso_byte
);

  // reset empties the result pipe
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(miso_byte))
    else $error("stalled result changed");

  // with no result waiting the block always takes a word
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("not ready with empty output");

  // a fresh result follows a taken word through the read stage, then the output register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && !$past(rst) && !$past(rst, 2) |->
      $past(in_valid && in_ready, 2))
    else $error("result without matching word");

endmodule

bind spi_sram_slave_with_modes_top spisram_checker u_spisram_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .miso_byte (miso_byte)
);
